>>> rtl/tdrr_pkg.sv
// Package for the text decimal-to-Roman rewriter.
// Holds the word types of both channels, the internal string types and character codes.
// Depends on nothing.
package tdrr_pkg;

  // Largest number of output words that one input word can cause.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned LenW       = $clog2(MaxResults + 1);

  // Significant digits held per number, and the count that marks a pass-through run.
  localparam int unsigned DigitSlots = 4;
  localparam logic [2:0]  SigPass    = 3'd5;

  // ASCII codes used when building results.
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharI    = 8'h49;
  localparam logic [7:0] CharV    = 8'h56;
  localparam logic [7:0] CharX    = 8'h58;
  localparam logic [7:0] CharL    = 8'h4C;
  localparam logic [7:0] CharC    = 8'h43;
  localparam logic [7:0] CharD    = 8'h44;
  localparam logic [7:0] CharM    = 8'h4D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_word_t;

  // Up to four characters for one Roman digit position; ch[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] ch;
    logic [2:0]      len;
  } piece_t;

  // The whole result string of one input word; ch[0] goes out first.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] ch;
    logic [LenW-1:0]            len;
  } str_t;

endpackage

>>> rtl/text_decimal_to_roman_rewriter_top.sv
// Top level of the text decimal-to-Roman rewriter.
// Input register, one combinational rewrite step and a shifting result buffer.
// Depends on tdrr_pkg.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_word_i  (char_code, end_of_text)
//   out     | output    | out_valid_o / out_stall_i | out_word_o (out_char, last_of_run)
//
// An input word is taken into the input register and, once the result buffer is free,
// rewritten into the result buffer, from which its first output word is offered.
// Unless the output stalls, the result buffer sends one output word per cycle; an input
// word causes at most 16 output words; a word that causes none or one leaves the input
// running at one word per cycle as long as the output does not stall. The input stalls
// only while the buffer still holds more than the word being taken on the current edge.
// Reset clears the valid flags, the buffer count and the number-tracking state; the
// stored digits and characters carry no reset.
module text_decimal_to_roman_rewriter_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tdrr_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tdrr_pkg::out_word_t  out_word_o
);

  // Classification of text bytes in the C locale.
  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) ||
           ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
           ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
  endfunction

  // Roman characters for one decimal digit, given the unit, five and ten symbols.
  function automatic tdrr_pkg::piece_t roman_digit(logic [3:0] d, logic [7:0] one,
                                                   logic [7:0] five, logic [7:0] ten);
    tdrr_pkg::piece_t p;
    p = '0;
    case (d)
      4'd1: begin p.ch[0] = one; p.len = 3'd1; end
      4'd2: begin p.ch[0] = one; p.ch[1] = one; p.len = 3'd2; end
      4'd3: begin p.ch[0] = one; p.ch[1] = one; p.ch[2] = one; p.len = 3'd3; end
      4'd4: begin p.ch[0] = one; p.ch[1] = five; p.len = 3'd2; end
      4'd5: begin p.ch[0] = five; p.len = 3'd1; end
      4'd6: begin p.ch[0] = five; p.ch[1] = one; p.len = 3'd2; end
      4'd7: begin p.ch[0] = five; p.ch[1] = one; p.ch[2] = one; p.len = 3'd3; end
      4'd8: begin
        p.ch[0] = five; p.ch[1] = one; p.ch[2] = one; p.ch[3] = one; p.len = 3'd4;
      end
      4'd9: begin p.ch[0] = one; p.ch[1] = ten; p.len = 3'd2; end
      default: p = '0;
    endcase
    return p;
  endfunction

  // Appends a piece at the current end of a string.
  function automatic tdrr_pkg::str_t append(tdrr_pkg::str_t s, tdrr_pkg::piece_t p);
    tdrr_pkg::str_t r;
    r = s;
    for (int i = 0; i < tdrr_pkg::MaxResults; i++) begin
      for (int k = 0; k < 4; k++) begin
        if ((3'(k) < p.len) &&
            (tdrr_pkg::LenW'(i) == s.len + tdrr_pkg::LenW'(k))) begin
          r.ch[i] = p.ch[k];
        end
      end
    end
    r.len = s.len + tdrr_pkg::LenW'(p.len);
    return r;
  endfunction

  function automatic tdrr_pkg::piece_t one_char(logic [7:0] c);
    tdrr_pkg::piece_t p;
    p       = '0;
    p.ch[0] = c;
    p.len   = 3'd1;
    return p;
  endfunction

  // Text for a finished number: Roman if it ended cleanly and lies in 1..3999, otherwise
  // its significant digits in decimal, one zero for a run of zeros, none in pass-through.
  function automatic tdrr_pkg::str_t flush_number(logic [2:0] cnt, logic [3:0][3:0] dg,
                                                  logic term);
    tdrr_pkg::str_t r;
    logic [3:0]     th, hu, te, on;
    r  = '0;
    th = '0;
    hu = '0;
    te = '0;
    on = '0;
    case (cnt)
      3'd1: on = dg[0];
      3'd2: begin te = dg[0]; on = dg[1]; end
      3'd3: begin hu = dg[0]; te = dg[1]; on = dg[2]; end
      3'd4: begin th = dg[0]; hu = dg[1]; te = dg[2]; on = dg[3]; end
      default: on = '0;
    endcase
    if (cnt == 3'd0) begin
      r = append(r, one_char(tdrr_pkg::CharZero));
    end else if (cnt < tdrr_pkg::SigPass) begin
      if (term && ((cnt != 3'd4) || (dg[0] <= 4'd3))) begin
        r = append(r, roman_digit(th, tdrr_pkg::CharM, tdrr_pkg::CharM, tdrr_pkg::CharM));
        r = append(r, roman_digit(hu, tdrr_pkg::CharC, tdrr_pkg::CharD, tdrr_pkg::CharM));
        r = append(r, roman_digit(te, tdrr_pkg::CharX, tdrr_pkg::CharL, tdrr_pkg::CharC));
        r = append(r, roman_digit(on, tdrr_pkg::CharI, tdrr_pkg::CharV, tdrr_pkg::CharX));
      end else begin
        for (int k = 0; k < 4; k++) begin
          r.ch[k] = tdrr_pkg::CharZero | {4'd0, dg[k]};
        end
        r.len = tdrr_pkg::LenW'(cnt);
      end
    end
    return r;
  endfunction

  // Input register.
  logic               in_vld_q;
  tdrr_pkg::in_word_t in_q;

  // Number-tracking state.
  logic            prev_delim_q, prev_delim_d;
  logic            num_act_q, num_act_d;
  logic [2:0]      sig_cnt_q, sig_cnt_d;
  logic [3:0][3:0] dbuf_q, dbuf_d;

  // Result buffer: words leave from slot 0, rem_q counts those still to send.
  logic [tdrr_pkg::MaxResults-1:0][7:0] obuf_q;
  logic [tdrr_pkg::LenW-1:0]            rem_q;

  logic           pop, buf_free, load, in_take;
  logic [7:0]     c;
  logic [3:0]     dig;
  tdrr_pkg::str_t fl, res;

  assign pop      = out_valid_o & ~out_stall_i;
  assign buf_free = (rem_q == '0) | (pop & (rem_q == tdrr_pkg::LenW'(1)));
  assign load     = in_vld_q & buf_free;
  assign in_stall_o = in_vld_q & ~load;
  assign in_take  = in_valid_i & ~in_stall_o;

  assign out_valid_o            = (rem_q != '0);
  assign out_word_o.out_char    = obuf_q[0];
  assign out_word_o.last_of_run = (rem_q == tdrr_pkg::LenW'(1));

  // One rewrite step on the registered word. A digit that continues a number is held back
  // unless the run is too long; held digits leave once the run ends or grows too long.
  always_comb begin
    c            = in_q.char_code;
    dig          = c[3:0];
    fl           = flush_number(sig_cnt_q, dbuf_q, in_q.end_of_text | is_delim(c));
    res          = '0;
    prev_delim_d = prev_delim_q;
    num_act_d    = num_act_q;
    sig_cnt_d    = sig_cnt_q;
    dbuf_d       = dbuf_q;
    if (in_q.end_of_text) begin
      if (num_act_q) begin
        res = fl;
      end
      prev_delim_d = 1'b1;
      num_act_d    = 1'b0;
      sig_cnt_d    = '0;
    end else if (num_act_q && is_digit(c)) begin
      if (sig_cnt_q >= tdrr_pkg::SigPass) begin
        res = append(res, one_char(c));
      end else if ((sig_cnt_q == 3'd0) && (dig == 4'd0)) begin
        // Leading zero: only remembered through a zero count.
        res = '0;
      end else if (sig_cnt_q < 3'd4) begin
        dbuf_d[sig_cnt_q[1:0]] = dig;
        sig_cnt_d = sig_cnt_q + 3'd1;
      end else begin
        // A fifth significant digit: the run can no longer be converted.
        for (int k = 0; k < 4; k++) begin
          res.ch[k] = tdrr_pkg::CharZero | {4'd0, dbuf_q[k]};
        end
        res.ch[4] = c;
        res.len   = tdrr_pkg::LenW'(5);
        sig_cnt_d = tdrr_pkg::SigPass;
      end
      prev_delim_d = 1'b0;
    end else if (!num_act_q && is_digit(c) && prev_delim_q) begin
      num_act_d = 1'b1;
      sig_cnt_d = '0;
      if (dig != 4'd0) begin
        dbuf_d[0] = dig;
        sig_cnt_d = 3'd1;
      end
      prev_delim_d = 1'b0;
    end else begin
      if (num_act_q) begin
        res       = fl;
        num_act_d = 1'b0;
        sig_cnt_d = '0;
      end
      res          = append(res, one_char(c));
      prev_delim_d = is_delim(c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      prev_delim_q <= 1'b1;
      num_act_q    <= 1'b0;
      sig_cnt_q    <= '0;
      rem_q        <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        prev_delim_q <= prev_delim_d;
        num_act_q    <= num_act_d;
        sig_cnt_q    <= sig_cnt_d;
        rem_q        <= res.len;
      end else if (pop) begin
        rem_q <= rem_q - tdrr_pkg::LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (load) begin
      dbuf_q <= dbuf_d;
      obuf_q <= res.ch;
    end else if (pop) begin
      obuf_q <= obuf_q >> 8;
    end
  end

`ifndef SYNTHESIS
  // The buffer never claims more words than one input word can cause.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= tdrr_pkg::LenW'(tdrr_pkg::MaxResults))
    else $error("result count out of range");

  // A new result string is loaded only when at most the departing word is left.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (rem_q <= tdrr_pkg::LenW'(1)))
    else $error("result buffer overwritten");

  // The significant digit count never passes the pass-through mark.
  a_sig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_cnt_q <= tdrr_pkg::SigPass)
    else $error("digit count out of range");

  // End of text returns the tracking state to the start of a new text.
  a_eot_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_q.end_of_text) |=> (prev_delim_q && !num_act_q && (sig_cnt_q == 3'd0)))
    else $error("state not cleared after end of text");
`endif

endmodule
